### hw/rtl/tspi_pkg.sv
// ----------------------------------------------------------------------------
// Tunnel SPI table package
// Shared types, command and status codes and default sizes.
// ----------------------------------------------------------------------------
package tspi_pkg;

    localparam int ENTRIES_DEF  = 64;
    localparam int REF_BITS_DEF = 16;

    localparam logic [31:0] SPI_MIN = 32'h0000_0001;
    localparam logic [31:0] SPI_MAX = 32'hffff_ffff;

    typedef enum logic [1:0] {
        CMD_LOOKUP = 2'd0,
        CMD_ALLOC  = 2'd1,
        CMD_FREE   = 2'd2,
        CMD_RSVD   = 2'd3
    } t_cmd;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_NOTFOUND = 2'd1,
        ST_FULL     = 2'd2,
        ST_NOSPI    = 2'd3
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_DECIDE,
        S_SPI_SCAN,
        S_SPI_NEXT,
        S_WRITE,
        S_OUT
    } t_state;

    // memory write request from the controller to the entry store
    typedef struct packed {
        logic        we;
        logic        valid;
        logic [63:0] addr_hi;
        logic [63:0] addr_lo;
        logic [31:0] spi;
    } t_ent_wr;

endpackage

### hw/rtl/tspi_store.sv
// ----------------------------------------------------------------------------
// Tunnel SPI entry store
// Synchronous memory of entries plus valid bits, one read and one write port.
// ----------------------------------------------------------------------------
module tspi_store
    import tspi_pkg::*;
#(
    parameter int ENTRIES  = ENTRIES_DEF,
    parameter int REF_BITS = REF_BITS_DEF,
    localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic [IW-1:0]       i_rd_idx,
    output logic                o_rd_valid,
    output logic [63:0]         o_rd_hi,
    output logic [63:0]         o_rd_lo,
    output logic [31:0]         o_rd_spi,
    output logic [REF_BITS-1:0] o_rd_refs,
    input  logic [IW-1:0]       i_wr_idx,
    input  t_ent_wr             i_wr,
    input  logic                i_refs_we,
    input  logic [REF_BITS-1:0] i_wr_refs
);

    logic [63:0]         r_mem_hi   [ENTRIES];
    logic [63:0]         r_mem_lo   [ENTRIES];
    logic [31:0]         r_mem_spi  [ENTRIES];
    logic [REF_BITS-1:0] r_mem_refs [ENTRIES];
    logic [ENTRIES-1:0]  r_valid;

    always_ff @(posedge i_clk) begin
        if (i_wr.we) begin
            r_mem_hi[i_wr_idx]  <= i_wr.addr_hi;
            r_mem_lo[i_wr_idx]  <= i_wr.addr_lo;
            r_mem_spi[i_wr_idx] <= i_wr.spi;
        end
        if (i_refs_we) begin
            r_mem_refs[i_wr_idx] <= i_wr_refs;
        end
        o_rd_hi   <= r_mem_hi[i_rd_idx];
        o_rd_lo   <= r_mem_lo[i_rd_idx];
        o_rd_spi  <= r_mem_spi[i_rd_idx];
        o_rd_refs <= r_mem_refs[i_rd_idx];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid    <= '0;
            o_rd_valid <= 1'b0;
        end else begin
            if (i_refs_we) begin
                r_valid[i_wr_idx] <= i_wr.valid;
            end
            o_rd_valid <= r_valid[i_rd_idx];
        end
    end

endmodule

### hw/rtl/tspi_ctrl.sv
// ----------------------------------------------------------------------------
// Tunnel SPI table controller
// Sequencer: address scan, SPI candidate scan, slot pick and write back.
// ----------------------------------------------------------------------------
module tspi_ctrl
    import tspi_pkg::*;
#(
    parameter int ENTRIES  = ENTRIES_DEF,
    parameter int REF_BITS = REF_BITS_DEF,
    localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_req_valid,
    output logic                o_req_ready,
    input  logic [1:0]          i_cmd,
    input  logic [63:0]         i_addr_hi,
    input  logic [63:0]         i_addr_lo,
    output logic                o_rsp_valid,
    input  logic                i_rsp_ready,
    output logic [31:0]         o_spi,
    output logic [1:0]          o_status,
    output logic [IW-1:0]       o_rd_idx,
    input  logic                i_rd_valid,
    input  logic [63:0]         i_rd_hi,
    input  logic [63:0]         i_rd_lo,
    input  logic [31:0]         i_rd_spi,
    input  logic [REF_BITS-1:0] i_rd_refs,
    output logic [IW-1:0]       o_wr_idx,
    output t_ent_wr             o_wr,
    output logic                o_refs_we,
    output logic [REF_BITS-1:0] o_wr_refs
);

    localparam logic [IW:0]         LAST    = (IW+1)'(ENTRIES - 1);
    localparam logic [REF_BITS-1:0] REF_MAX = '1;

    t_state r_state, n_state;
    t_cmd   r_cmd;
    logic [63:0] r_hi, r_lo;
    logic [IW:0] r_cnt, n_cnt;     // read address being issued
    logic        r_rd_pend;        // a read issued last cycle
    logic [IW-1:0] r_rd_at;        // index of read in flight
    logic        r_hit;
    logic [IW-1:0] r_hit_idx;
    logic [31:0] r_hit_spi;
    logic [REF_BITS-1:0] r_hit_refs;
    logic        r_free_ok;
    logic [IW-1:0] r_free_idx;
    logic [31:0] r_last, r_cand, r_start;
    logic        r_wrapped, r_used;
    logic [31:0] r_spi;
    logic [1:0]  r_status;
    logic        r_ov;
    logic [31:0] r_out_spi;
    logic [1:0]  r_out_status;

    logic scan_end;
    logic match_now;
    logic out_load;
    assign scan_end  = (r_cnt == LAST + 1'b1);
    assign match_now = r_rd_pend && i_rd_valid && i_rd_hi == r_hi && i_rd_lo == r_lo;
    // output register free, or its response leaves this cycle
    assign out_load  = (r_state == S_OUT) && (!r_ov || i_rsp_ready);

    assign o_rd_idx    = r_cnt[IW-1:0];
    assign o_req_ready = (r_state == S_IDLE);
    assign o_rsp_valid = r_ov;
    assign o_spi       = r_out_spi;
    assign o_status    = r_out_status;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:     if (i_req_valid) n_state = S_SCAN;
            S_SCAN:     if (scan_end && !r_rd_pend) n_state = S_DECIDE;
            S_DECIDE: begin
                if (r_cmd == CMD_ALLOC && !r_hit) n_state = S_SPI_SCAN;
                else                              n_state = S_OUT;
            end
            S_SPI_SCAN: if (scan_end && !r_rd_pend) n_state = S_SPI_NEXT;
            S_SPI_NEXT: begin
                if (!r_used) n_state = S_WRITE;
                else if (r_wrapped && r_cand + 32'd1 >= r_start) n_state = S_OUT;
                else n_state = S_SPI_SCAN;
            end
            S_WRITE:    n_state = S_OUT;
            S_OUT:      if (out_load) n_state = S_IDLE;
            default:    n_state = S_IDLE;
        endcase
    end

    always_comb begin
        n_cnt = r_cnt;
        if ((r_state == S_SCAN || r_state == S_SPI_SCAN) && !scan_end) n_cnt = r_cnt + 1'b1;
        if (r_state == S_IDLE || r_state == S_DECIDE || r_state == S_SPI_NEXT) n_cnt = '0;
    end

    // write-back port
    always_comb begin
        o_wr      = '0;
        o_wr_idx  = r_hit_idx;
        o_refs_we = 1'b0;
        o_wr_refs = r_hit_refs;
        if (r_state == S_DECIDE && r_hit) begin
            if (r_cmd == CMD_ALLOC) begin
                o_refs_we = 1'b1;
                o_wr.valid = 1'b1;
                o_wr_refs = (r_hit_refs < REF_MAX) ? r_hit_refs + 1'b1 : r_hit_refs;
            end else if (r_cmd == CMD_FREE) begin
                o_refs_we = 1'b1;
                o_wr.valid = (r_hit_refs > REF_BITS'(1));
                o_wr_refs = (r_hit_refs > REF_BITS'(1)) ? r_hit_refs - 1'b1 : '0;
            end
        end else if (r_state == S_WRITE && r_free_ok) begin
            o_wr_idx   = r_free_idx;
            o_refs_we  = 1'b1;
            o_wr.we    = 1'b1;
            o_wr.valid = 1'b1;
            o_wr.addr_hi = r_hi;
            o_wr.addr_lo = r_lo;
            o_wr.spi   = r_cand;
            o_wr_refs  = REF_BITS'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_ov         <= 1'b0;
            r_out_spi    <= '0;
            r_out_status <= '0;
            r_last       <= '0;
            r_cnt        <= '0;
            r_rd_pend    <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_cnt     <= n_cnt;
            r_rd_pend <= (r_state == S_SCAN || r_state == S_SPI_SCAN) && !scan_end;
            if (out_load) begin
                r_ov         <= 1'b1;
                r_out_spi    <= r_spi;
                r_out_status <= r_status;
            end else if (i_rsp_ready) begin
                r_ov <= 1'b0;
            end
            if (r_state == S_DECIDE && r_cmd == CMD_ALLOC && !r_hit) begin
                r_last <= (r_last == '0 || r_last == SPI_MAX) ? SPI_MIN : r_last + 32'd1;
            end else if (r_state == S_SPI_NEXT && !r_used) begin
                r_last <= r_cand;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd_at <= r_cnt[IW-1:0];
        unique case (r_state)
            S_IDLE: begin
                r_cmd <= t_cmd'(i_cmd);
                r_hi  <= i_addr_hi;
                r_lo  <= i_addr_lo;
                r_hit <= 1'b0;
                r_free_ok <= 1'b0;
            end
            S_SCAN: begin
                if (match_now && !r_hit) begin
                    r_hit      <= 1'b1;
                    r_hit_idx  <= r_rd_at;
                    r_hit_spi  <= i_rd_spi;
                    r_hit_refs <= i_rd_refs;
                end
                if (r_rd_pend && !i_rd_valid && !r_free_ok) begin
                    r_free_ok  <= 1'b1;
                    r_free_idx <= r_rd_at;
                end
            end
            S_DECIDE: begin
                r_spi    <= r_hit ? r_hit_spi : '0;
                r_status <= r_hit ? ST_OK : ST_NOTFOUND;
                r_cand   <= (r_last == '0 || r_last == SPI_MAX) ? SPI_MIN : r_last + 32'd1;
                r_start  <= (r_last == '0 || r_last == SPI_MAX) ? SPI_MIN : r_last + 32'd1;
                r_wrapped <= 1'b0;
                r_used   <= 1'b0;
            end
            S_SPI_SCAN: begin
                if (r_rd_pend && i_rd_valid && i_rd_spi == r_cand) r_used <= 1'b1;
            end
            S_SPI_NEXT: begin
                r_used <= 1'b0;
                if (!r_used) begin
                    r_spi    <= r_free_ok ? r_cand : '0;
                    r_status <= r_free_ok ? ST_OK : ST_FULL;
                end else if (r_wrapped && r_cand + 32'd1 >= r_start) begin
                    r_spi    <= '0;
                    r_status <= ST_NOSPI;
                end else if (r_cand == SPI_MAX) begin
                    r_cand    <= SPI_MIN;
                    r_wrapped <= 1'b1;
                end else begin
                    r_cand <= r_cand + 32'd1;
                end
            end
            default: ;
        endcase
    end

endmodule

### hw/rtl/tunnel_spi_refcount_table.sv
// ----------------------------------------------------------------------------
// Tunnel SPI reference-count table
// Maps IPv6 source addresses to tunnel SPIs with reference counts.
// ----------------------------------------------------------------------------
// Usage: a request on the s_axis group carries cmd (lookup, allocate, free)
// and a 128-bit address; exactly one response (spi, status) follows on the
// m_axis group. Requests are handled one at a time.
// Every request walks the entry memory once, then the controller decides and
// responds; a new request is taken only once the last one has been loaded into
// the output register. An allocate of a new address also walks the memory
// once per SPI candidate tried, plus a write of the chosen slot.
// The single read port of the entry memory makes each of these walks sequential.
// Reset clears the valid bits and the rolling SPI counter at once; no
// clearing pass is needed. A stalled response holds in the output register;
// one more request is taken and processed, and its response waits until the
// output register is free.
// ----------------------------------------------------------------------------
module tunnel_spi_refcount_table
    import tspi_pkg::*;
#(
    parameter int ENTRIES  = ENTRIES_DEF,
    parameter int REF_BITS = REF_BITS_DEF
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [135:0] s_axis_tdata,  // cmd[1:0], addr_hi[65:2], addr_lo[129:66], zero
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [39:0]  m_axis_tdata   // spi[31:0], status[33:32], zero
);

    localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

    logic [IW-1:0]       rd_idx, wr_idx;
    logic                rd_valid, refs_we;
    logic [63:0]         rd_hi, rd_lo;
    logic [31:0]         rd_spi, spi;
    logic [REF_BITS-1:0] rd_refs, wr_refs;
    logic [1:0]          status;
    t_ent_wr             wr;

    tspi_store #(.ENTRIES(ENTRIES), .REF_BITS(REF_BITS)) u_store (
        .i_clk, .i_rst_n,
        .i_rd_idx(rd_idx), .o_rd_valid(rd_valid), .o_rd_hi(rd_hi), .o_rd_lo(rd_lo),
        .o_rd_spi(rd_spi), .o_rd_refs(rd_refs),
        .i_wr_idx(wr_idx), .i_wr(wr), .i_refs_we(refs_we), .i_wr_refs(wr_refs)
    );

    tspi_ctrl #(.ENTRIES(ENTRIES), .REF_BITS(REF_BITS)) u_ctrl (
        .i_clk, .i_rst_n,
        .i_req_valid(s_axis_tvalid), .o_req_ready(s_axis_tready),
        .i_cmd(s_axis_tdata[1:0]), .i_addr_hi(s_axis_tdata[65:2]),
        .i_addr_lo(s_axis_tdata[129:66]),
        .o_rsp_valid(m_axis_tvalid), .i_rsp_ready(m_axis_tready),
        .o_spi(spi), .o_status(status),
        .o_rd_idx(rd_idx), .i_rd_valid(rd_valid), .i_rd_hi(rd_hi), .i_rd_lo(rd_lo),
        .i_rd_spi(rd_spi), .i_rd_refs(rd_refs),
        .o_wr_idx(wr_idx), .o_wr(wr), .o_refs_we(refs_we), .o_wr_refs(wr_refs)
    );

    assign m_axis_tdata = {6'd0, status, spi};

endmodule

### hw/rtl/tspi_checker.sv
// ----------------------------------------------------------------------------
// Tunnel SPI table port checker
// Port-level properties of the request/response sequencing.
// ----------------------------------------------------------------------------
module tspi_checker
    import tspi_pkg::*;
(
    input logic         i_clk,
    input logic         i_rst_n,
    input logic         s_axis_tvalid,
    input logic         s_axis_tready,
    input logic         m_axis_tvalid,
    input logic         m_axis_tready,
    input logic [39:0]  m_axis_tdata
);

    // no response right after reset
    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid) else $error("response valid after reset");

    // an accepted request keeps the input closed while it is processed
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
        else $error("request taken while busy");

    // a zero spi with ok status is impossible
    a_ok_spi: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tdata[33:32] == ST_OK) |-> m_axis_tdata[31:0] != '0)
        else $error("ok status with zero spi");

    // padding bits stay zero
    a_pad: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> m_axis_tdata[39:34] == '0) else $error("nonzero padding");

    // response holds while stalled
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
        else $error("stalled response changed");

endmodule

bind tunnel_spi_refcount_table tspi_checker u_tspi_checker (
    .i_clk, .i_rst_n, .s_axis_tvalid, .s_axis_tready,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata
);

### tb/tb_tunnel_spi_refcount_table.sv
// ----------------------------------------------------------------------------
// Tunnel SPI table testbench
// Drives lookup, allocate, free and reserved-command requests with random handshake gaps and
// checks every response against a behavioral model of the entry table.
// ----------------------------------------------------------------------------
module tb_tunnel_spi_refcount_table;
    import tspi_pkg::*;

    localparam int NENT   = ENTRIES_DEF;
    localparam int REFMAX = (1 << REF_BITS_DEF) - 1;

    typedef struct {
        t_cmd        cmd;
        logic [63:0] hi;
        logic [63:0] lo;
    } t_req;

    typedef struct {
        logic [31:0] spi;
        t_status     status;
    } t_rsp;

    logic         i_clk;
    logic         i_rst_n;
    logic         s_axis_tvalid;
    logic         s_axis_tready;
    logic [135:0] s_axis_tdata;   // cmd, addr_hi, addr_lo, zero
    logic         m_axis_tvalid;
    logic         m_axis_tready;
    logic [39:0]  m_axis_tdata;   // spi, status, zero

    tunnel_spi_refcount_table u_top (.*);

    // table model
    bit          tbl_valid [NENT];
    logic [63:0] tbl_hi    [NENT];
    logic [63:0] tbl_lo    [NENT];
    logic [31:0] tbl_spi   [NENT];
    int          tbl_refs  [NENT];
    logic [31:0] roll_spi;

    t_req pending_reqs[$];
    t_rsp expected_rsps[$];
    int   errors;
    int   hold_cycles;
    bit   pause_sender;
    bit   in_acc;         // request accepted at the last rising edge

    // a few addresses reused often so that alloc/free hit known entries
    logic [63:0] pool_hi [16];
    logic [63:0] pool_lo [16];

    function automatic int find_addr(logic [63:0] hi, logic [63:0] lo);
        for (int i = 0; i < NENT; i++)
            if (tbl_valid[i] && tbl_hi[i] == hi && tbl_lo[i] == lo) return i;
        return -1;
    endfunction

    function automatic bit spi_taken(logic [31:0] s);
        for (int i = 0; i < NENT; i++)
            if (tbl_valid[i] && tbl_spi[i] == s) return 1;
        return 0;
    endfunction

    function automatic t_rsp table_response(t_req r);
        t_rsp        o;
        int          idx;
        int          slot;
        logic [31:0] s;
        bit          found;
        o.spi    = '0;
        o.status = ST_NOTFOUND;
        idx      = find_addr(r.hi, r.lo);
        if (r.cmd == CMD_ALLOC) begin
            if (idx >= 0) begin
                if (tbl_refs[idx] < REFMAX) tbl_refs[idx]++;
                o.spi    = tbl_spi[idx];
                o.status = ST_OK;
            end else begin
                if (roll_spi < SPI_MIN || roll_spi >= SPI_MAX) roll_spi = SPI_MIN;
                else roll_spi++;
                // at most NENT SPIs are taken, so the search ends quickly
                found = 0;
                s     = roll_spi;
                for (int k = 0; k <= NENT && !found; k++) begin
                    if (!spi_taken(s)) found = 1;
                    else s = (s == SPI_MAX) ? SPI_MIN : s + 1;
                end
                if (!found) begin
                    o.status = ST_NOSPI;
                end else begin
                    roll_spi = s;
                    slot     = -1;
                    for (int i = NENT - 1; i >= 0; i--)
                        if (!tbl_valid[i]) slot = i;
                    if (slot < 0) begin
                        o.status = ST_FULL;
                    end else begin
                        tbl_valid[slot] = 1;
                        tbl_hi[slot]    = r.hi;
                        tbl_lo[slot]    = r.lo;
                        tbl_spi[slot]   = s;
                        tbl_refs[slot]  = 1;
                        o.spi           = s;
                        o.status        = ST_OK;
                    end
                end
            end
        end else if (idx >= 0) begin
            o.spi    = tbl_spi[idx];
            o.status = ST_OK;
            if (r.cmd == CMD_FREE) begin
                if (tbl_refs[idx] <= 1) begin
                    tbl_refs[idx]  = 0;
                    tbl_valid[idx] = 0;
                end else begin
                    tbl_refs[idx]--;
                end
            end
        end
        return o;
    endfunction

    function automatic logic [63:0] rand64();
        case ($urandom_range(0, 5))
            0: return '0;
            1: return '1;
            default: return {$urandom(), $urandom()};
        endcase
    endfunction

    function automatic void add_req(t_cmd c, logic [63:0] hi, logic [63:0] lo);
        t_req r;
        r.cmd = c;
        r.hi  = hi;
        r.lo  = lo;
        pending_reqs.push_back(r);
    endfunction

    function automatic int gap_len();
        if ($urandom_range(0, 3) == 0) return 0;
        return ($urandom_range(0, 19) == 0) ? $urandom_range(10, 60) : $urandom_range(0, 3);
    endfunction

    initial begin
        i_clk = 0;
        forever #2 i_clk = ~i_clk;
    end

    // driver
    int send_gap;
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 0;
            send_gap      <= 0;
        end else if (s_axis_tvalid && !in_acc) begin
            // hold the offered request
        end else begin
            t_req r;
            int   gap;
            gap = send_gap;
            if (in_acc) gap = gap_len();
            if (gap > 0 || pause_sender || pending_reqs.size() == 0) begin
                s_axis_tvalid <= 0;
                send_gap      <= (gap > 0) ? gap - 1 : 0;
            end else begin
                r = pending_reqs.pop_front();
                s_axis_tdata  <= {6'd0, r.lo, r.hi, r.cmd};
                s_axis_tvalid <= 1;
                send_gap      <= 0;
            end
        end
    end

    // prediction on acceptance
    always @(posedge i_clk) begin
        in_acc <= i_rst_n && s_axis_tvalid && s_axis_tready;
        if (i_rst_n && s_axis_tvalid && s_axis_tready) begin
            t_req r;
            r.cmd = t_cmd'(s_axis_tdata[1:0]);
            r.hi  = s_axis_tdata[65:2];
            r.lo  = s_axis_tdata[129:66];
            expected_rsps.push_back(table_response(r));
        end
    end

    // receiver ready
    int rdy_gap;
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 0;
            rdy_gap       <= 0;
        end else if (hold_cycles > 0) begin
            m_axis_tready <= 0;
            hold_cycles   <= hold_cycles - 1;
        end else if (rdy_gap > 0) begin
            m_axis_tready <= 0;
            rdy_gap       <= rdy_gap - 1;
        end else begin
            m_axis_tready <= 1;
            rdy_gap       <= gap_len();
        end
    end

    // monitor
    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            t_rsp e;
            if (expected_rsps.size() == 0) begin
                $error("response with none expected: %h", m_axis_tdata);
                errors++;
            end else begin
                e = expected_rsps.pop_front();
                if (m_axis_tdata[31:0] !== e.spi) begin
                    $error("spi: expected %h actual %h", e.spi, m_axis_tdata[31:0]);
                    errors++;
                end
                if (m_axis_tdata[33:32] !== e.status) begin
                    $error("status: expected %0d actual %0d", e.status, m_axis_tdata[33:32]);
                    errors++;
                end
            end
        end
    end

    initial begin
        #20000000;
        $display("tb_tunnel_spi_refcount_table: FAIL");
        $finish;
    end

    task automatic wait_drained();
        while (pending_reqs.size() != 0 || s_axis_tvalid || expected_rsps.size() != 0)
            @(posedge i_clk);
    endtask

    initial begin
        int p;
        errors        = 0;
        hold_cycles   = 0;
        pause_sender  = 0;
        in_acc        = 0;
        roll_spi      = '0;
        s_axis_tvalid = 0;
        s_axis_tdata  = '0;
        m_axis_tready = 0;
        for (int i = 0; i < NENT; i++) begin
            tbl_valid[i] = 0;
            tbl_refs[i]  = 0;
        end
        for (int i = 0; i < 16; i++) begin
            pool_hi[i] = rand64();
            pool_lo[i] = rand64();
        end
        pool_hi[0] = '0;
        pool_lo[0] = '0;
        pool_hi[1] = '1;
        pool_lo[1] = '1;
        i_rst_n = 0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1;

        // directed: absent lookups/frees, every command, extremes of the address
        add_req(CMD_LOOKUP, '0, '0);
        add_req(CMD_FREE, '1, '1);
        add_req(CMD_ALLOC, '0, '0);
        add_req(CMD_ALLOC, '1, '1);
        add_req(CMD_ALLOC, '0, '0);
        add_req(CMD_RSVD, '0, '0);
        add_req(CMD_LOOKUP, '1, '1);
        add_req(CMD_FREE, '0, '0);
        add_req(CMD_FREE, '0, '0);
        add_req(CMD_LOOKUP, '0, '0);
        add_req(CMD_RSVD, 64'h5555_5555_5555_5555, 64'haaaa_aaaa_aaaa_aaaa);
        add_req(CMD_FREE, '1, '1);

        // fill the table past full, then later free every entry: table full case
        for (int i = 0; i < NENT + 3; i++) add_req(CMD_ALLOC, 64'd1000 + i, 64'hdead);
        wait_drained();
        // long receiver stall while requests keep coming
        for (int i = 0; i < 10; i++) add_req(CMD_LOOKUP, 64'd1000 + i, 64'hdead);
        hold_cycles = 2000;
        wait_drained();
        for (int i = 0; i < NENT; i++) add_req(CMD_FREE, 64'd1000 + i, 64'hdead);

        // random traffic, mostly on the pool so entries get reused
        for (int n = 0; n < 1750; n++) begin
            t_cmd c;
            p = $urandom_range(0, 99);
            c = (p < 45) ? CMD_ALLOC : (p < 75) ? CMD_FREE : (p < 95) ? CMD_LOOKUP : CMD_RSVD;
            if ($urandom_range(0, 9) < 8) begin
                p = $urandom_range(0, 15);
                add_req(c, pool_hi[p], pool_lo[p]);
            end else begin
                add_req(c, rand64(), rand64());
            end
            if (n == 900) begin
                wait_drained();
                pause_sender = 1;
                repeat (50) @(posedge i_clk);
                pause_sender = 0;
            end
        end

        wait_drained();
        repeat (400) @(posedge i_clk);
        if (errors == 0 && expected_rsps.size() == 0)
            $display("tb_tunnel_spi_refcount_table: PASS");
        else
            $display("tb_tunnel_spi_refcount_table: FAIL");
        $finish;
    end

endmodule
